@@ rtl/smsel_pkg.sv @@
package smsel_pkg;

	// Capacity of the chain and width of one sample.
	localparam int MAX_SAMPLES  = 64;
	localparam int SAMPLE_WIDTH = 32;

	// Sample count runs from 0 to MAX_SAMPLES inclusive.
	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
	// Shift count runs from 0 to (MAX_SAMPLES - 1) / 2.
	localparam int SHIFT_W = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
	localparam int RES_W   = SAMPLE_WIDTH + 1;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic ins;    // insert the broadcast sample
		logic shift;  // every cell but the last takes the value of its right neighbor
		logic clear;  // drop all held samples
	} ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

endpackage

@@ rtl/smsel_cell.sv @@
module smsel_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  smsel_pkg::ctl_t     ctl,
	input  smsel_pkg::sample_t  x,
	input  smsel_pkg::sample_t  left_val,
	input  logic                left_gt,
	input  logic                left_vld,
	input  smsel_pkg::sample_t  right_val,
	output smsel_pkg::sample_t  val,
	output logic                gt,
	output logic                vld
);

	smsel_pkg::sample_t val_q;
	logic               vld_q;
	logic               take;

	// The held sample is larger than the new one, so it moves one place right.
	assign gt   = vld_q && (val_q > x);
	// A cell takes a value if it is displaced or if it is the first free cell.
	assign take = gt || (!vld_q && left_vld);
	assign val  = val_q;
	assign vld  = vld_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= right_val;
		end else if (ctl.ins && take) begin
			val_q <= left_gt ? left_val : x;
		end
	end

	// Clear and insert never come in the same cycle, since the input is
	// stalled while a set is being finished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				vld_q <= 1'b0;
			end else if (ctl.ins && take) begin
				vld_q <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/set_median_select_top.sv @@
// Streaming median of a set of signed samples.
//
// Input channel: sample and last with valid / stall. One item is taken per
// cycle while no set is being finished; each item enters an insertion chain
// that keeps the set in ascending order. An item with last = 1 closes the set.
// Output channel: median_twice (twice the median, exact) and overflowed with
// result_valid / result_stall, one item per set.
//
// Drain: after the last item of a set of n held samples is taken, the chain
// shifts toward cell 0 by (n - 1) / 2 places so that the middle samples
// reach cells 0 and 1, and then the result is registered. The input is
// stalled for the whole drain; all other items are taken at one per cycle.
// Samples that arrive while the chain is full are dropped and flagged.
// A result waits in the output register while the receiver stalls, and new
// items are still taken; the next set is only held at its end until the
// output register is free. Reset empties the chain and the output register.
module set_median_select_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    valid,
	output logic                                    stall,
	input  logic signed [smsel_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic                                    last,
	output logic                                    result_valid,
	input  logic                                    result_stall,
	output logic signed [smsel_pkg::RES_W-1:0]      median_twice,
	output logic                                    overflowed
);

	localparam int N  = smsel_pkg::MAX_SAMPLES;
	localparam int SW = smsel_pkg::SAMPLE_WIDTH;
	localparam int HI = (N > 1) ? 1 : 0;

	smsel_pkg::state_t              state_q;
	logic [smsel_pkg::CNT_W-1:0]    held_count_q;
	logic [smsel_pkg::SHIFT_W-1:0]  shift_q;
	logic                           odd_q;
	logic                           dropped_q;
	logic                           result_valid_q;
	logic signed [smsel_pkg::RES_W-1:0] median_q;
	logic                           overflowed_q;

	smsel_pkg::ctl_t                ctl;
	smsel_pkg::sample_t             cell_val [N];
	logic [N-1:0]                   cell_gt;
	logic [N-1:0]                   cell_vld;

	logic                           accept;
	logic                           full;
	logic                           draining;
	logic                           finish;
	logic [smsel_pkg::CNT_W-1:0]    mid_base;
	logic [smsel_pkg::CNT_W-1:0]    new_count;
	logic signed [smsel_pkg::RES_W-1:0] twice;

	assign accept   = valid && !stall;
	assign full     = (held_count_q == smsel_pkg::CNT_W'(N));
	assign draining = (state_q == smsel_pkg::ST_DRAIN);
	// The set is finished once the middle samples sit in cells 0 and 1 and
	// the output register is free to take the result.
	assign finish   = draining && (shift_q == '0) && (!result_valid_q || !result_stall);

	assign ctl.ins   = accept && !full;
	assign ctl.shift = draining && (shift_q != '0);
	assign ctl.clear = finish;

	// Count after this item and the index of the lower middle sample.
	assign new_count = full ? held_count_q : held_count_q + smsel_pkg::CNT_W'(1);
	assign mid_base  = (new_count - smsel_pkg::CNT_W'(1)) >> 1;

	// Odd count: twice the middle sample. Even count: sum of both middles.
	assign twice = odd_q ? {cell_val[0], 1'b0}
	                     : {cell_val[0][SW-1], cell_val[0]} + {cell_val[HI][SW-1], cell_val[HI]};

	for (genvar i = 0; i < N; i++) begin : g_cell
		smsel_pkg::sample_t lv, rv;
		logic               lg, lvd;
		if (i == 0) begin : g_first
			assign lv  = '0;
			assign lg  = 1'b0;
			assign lvd = 1'b1;
		end else begin : g_inner
			assign lv  = cell_val[i-1];
			assign lg  = cell_gt[i-1];
			assign lvd = cell_vld[i-1];
		end
		if (i == N - 1) begin : g_end
			assign rv = cell_val[i];
		end else begin : g_mid
			assign rv = cell_val[i+1];
		end
		smsel_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.x         (sample),
			.left_val  (lv),
			.left_gt   (lg),
			.left_vld  (lvd),
			.right_val (rv),
			.val       (cell_val[i]),
			.gt        (cell_gt[i]),
			.vld       (cell_vld[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= smsel_pkg::ST_IDLE;
			held_count_q   <= '0;
			shift_q        <= '0;
			odd_q          <= 1'b0;
			dropped_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				smsel_pkg::ST_IDLE: begin
					if (accept) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							held_count_q <= new_count;
						end
						if (last) begin
							state_q <= smsel_pkg::ST_DRAIN;
							shift_q <= mid_base[smsel_pkg::SHIFT_W-1:0];
							odd_q   <= new_count[0];
						end
					end
				end
				smsel_pkg::ST_DRAIN: begin
					if (shift_q != '0) begin
						shift_q <= shift_q - smsel_pkg::SHIFT_W'(1);
					end else if (finish) begin
						state_q      <= smsel_pkg::ST_IDLE;
						held_count_q <= '0;
						dropped_q    <= 1'b0;
					end
				end
				default: begin
					state_q <= smsel_pkg::ST_IDLE;
				end
			endcase

			if (finish) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Result payload needs no reset; it is only looked at with result_valid.
	always_ff @(posedge clk) begin
		if (finish) begin
			median_q     <= twice;
			overflowed_q <= dropped_q;
		end
	end

	assign stall        = draining;
	assign result_valid = result_valid_q;
	assign median_twice = median_q;
	assign overflowed   = overflowed_q;

endmodule

@@ rtl/smsel_checker.sv @@
module smsel_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    valid,
	input logic                                    stall,
	input logic signed [smsel_pkg::SAMPLE_WIDTH-1:0] sample,
	input logic                                    last,
	input logic                                    result_valid,
	input logic                                    result_stall,
	input logic signed [smsel_pkg::RES_W-1:0]      median_twice,
	input logic                                    overflowed
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(median_twice) && $stable(overflowed))
		else $error("result payload changed while stalled");

	// Only the closing item of a set starts the drain.
	a_no_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !stall && !last |=> !stall)
		else $error("input stalled after an item without last");

	// The closing item always starts the drain.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !stall && last |=> stall)
		else $error("no drain after the last item of a set");

	// A new result only comes out of a drain.
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(stall))
		else $error("result appeared without a closed set");

endmodule

bind set_median_select_top smsel_checker u_smsel_checker (.*);
